### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the queue checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package smpq_pkg;

   // Number of entries held in the cell row
   localparam int CAPACITY = 512;

   localparam int ValueW = 31;
   localparam int TagW   = 10;
   localparam int OccW   = 10;
   localparam int CountW = $clog2(CAPACITY + 1);

   // Word packing
   localparam int ReqFieldW = ValueW + TagW;
   localparam int ReqDataW  = ((ReqFieldW + 7) / 8) * 8;
   localparam int RspFieldW = ValueW + TagW + OccW;
   localparam int RspDataW  = ((RspFieldW + 7) / 8) * 8;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

### rtl/smpq_ctrl.sv
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer: takes one word, runs it through the cell row, holds the result.
// ----------------------------------------------------------------------------
module smpq_ctrl
   import smpq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           slot_free;

   // Result slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTRL_IDLE: begin
            if (req_valid) begin
               state_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            if (slot_free) begin
               state_in = CTRL_IDLE;
            end
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         CTRL_EXEC: begin
            cmd.exec = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Result valid flag: set on execute, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/smpq_cells.sv
// ----------------------------------------------------------------------------
// smpq_cells
// Datapath: row of sorted shift cells, fill counter and result register.
// Cell 0 holds the smallest entry; larger values sit at higher cells.
// ----------------------------------------------------------------------------
module smpq_cells
   import smpq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   input  func_type          in_func,
   input  logic [ValueW-1:0] in_value,
   input  logic [TagW-1:0]   in_tag,
   output status_type        out_status,
   output logic [ValueW-1:0] out_value,
   output logic [TagW-1:0]   out_tag,
   output logic [OccW-1:0]   out_occ
);

   // Captured operation
   func_type          op_func_ff;
   logic [ValueW-1:0] op_value_ff;
   logic [TagW-1:0]   op_tag_ff;

   // Cell row
   logic [ValueW-1:0] cell_value_ff [CAPACITY];
   logic [TagW-1:0]   cell_tag_ff   [CAPACITY];
   logic [CAPACITY-1:0] below;

   logic [CountW-1:0] fill_ff;
   logic [CountW-1:0] fill_in;
   logic              full;
   logic              empty;
   logic              shift_up;
   logic              shift_down;

   // Result register
   status_type        res_status_ff;
   status_type        res_status_in;
   logic [ValueW-1:0] res_value_ff;
   logic [ValueW-1:0] res_value_in;
   logic [TagW-1:0]   res_tag_ff;
   logic [TagW-1:0]   res_tag_in;
   logic [OccW-1:0]   res_occ_ff;

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_func_ff  <= in_func;
         op_value_ff <= in_value;
         op_tag_ff   <= in_tag;
      end
   end

   assign full       = (fill_ff == CountW'(CAPACITY));
   assign empty      = (fill_ff == '0);
   assign shift_up   = cmd.exec && (op_func_ff == FUNC_INSERT) && !full;
   assign shift_down = cmd.exec && (op_func_ff == FUNC_REMOVE) && !empty;

   // Each cell compares with the new value and picks keep, new or shift
   genvar g;
   for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ValueW-1:0] ins_value;
      logic [TagW-1:0]   ins_tag;
      logic [ValueW-1:0] rem_value;
      logic [TagW-1:0]   rem_tag;

      // Occupied and strictly smaller than the new value
      assign below[g] = (CountW'(g) < fill_ff) && (cell_value_ff[g] < op_value_ff);

      if (g == 0) begin : g_head
         assign ins_value = below[g] ? cell_value_ff[g] : op_value_ff;
         assign ins_tag   = below[g] ? cell_tag_ff[g]   : op_tag_ff;
      end else begin : g_body
         always_comb begin
            if (below[g]) begin
               ins_value = cell_value_ff[g];
               ins_tag   = cell_tag_ff[g];
            end else if (below[g-1]) begin
               ins_value = op_value_ff;
               ins_tag   = op_tag_ff;
            end else begin
               ins_value = cell_value_ff[g-1];
               ins_tag   = cell_tag_ff[g-1];
            end
         end
      end

      if (g == CAPACITY - 1) begin : g_last
         assign rem_value = cell_value_ff[g];
         assign rem_tag   = cell_tag_ff[g];
      end else begin : g_inner
         assign rem_value = cell_value_ff[g+1];
         assign rem_tag   = cell_tag_ff[g+1];
      end

      always_ff @(posedge clock) begin
         if (shift_up) begin
            cell_value_ff[g] <= ins_value;
            cell_tag_ff[g]   <= ins_tag;
         end else if (shift_down) begin
            cell_value_ff[g] <= rem_value;
            cell_tag_ff[g]   <= rem_tag;
         end
      end
   end

   // Fill count and result
   always_comb begin
      fill_in       = fill_ff;
      res_status_in = ST_OK;
      res_value_in  = '0;
      res_tag_in    = '0;
      if (op_func_ff == FUNC_INSERT) begin
         if (full) begin
            res_status_in = ST_FULL;
         end else begin
            fill_in = fill_ff + CountW'(1);
         end
      end else begin
         if (empty) begin
            res_status_in = ST_EMPTY;
         end else begin
            fill_in      = fill_ff - CountW'(1);
            res_value_in = cell_value_ff[0];
            res_tag_in   = cell_tag_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.exec) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
         res_tag_ff    <= res_tag_in;
         res_occ_ff    <= OccW'(fill_in);
      end
   end

   assign out_status = res_status_ff;
   assign out_value  = res_value_ff;
   assign out_tag    = res_tag_ff;
   assign out_occ    = res_occ_ff;

endmodule

### rtl/sorted_min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Bounded min priority queue held as a row of sorted shift cells.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word contents
//  req_    | in        | tuser: func; tdata: in_value, in_tag
//  rsp_    | out       | tuser: status; tdata: out_value, out_tag, occupancy
//
//  Each word is captured in the idle state; the execute state then runs the
//  parallel compare and shift across all cells and loads the result register.
//  A new word is taken in the cycle after the result is loaded, while that
//  result may still wait. A stalled result holds the operation in its
//  execute cycle. Synchronous reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core
   import smpq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,   // [0] func
   input  logic [ReqDataW-1:0] req_tdata,   // [30:0] in_value, [40:31] in_tag
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [1:0]          rsp_tuser,   // [1:0] status
   output logic [RspDataW-1:0] rsp_tdata    // [30:0] out_value, [40:31] out_tag,
                                            // [50:41] occupancy
);

   ctrl_cmd_type      cmd;
   func_type          in_func;
   status_type        out_status;
   logic [ValueW-1:0] out_value;
   logic [TagW-1:0]   out_tag;
   logic [OccW-1:0]   out_occ;

   // Unpack the request word
   assign in_func = func_type'(req_tuser);

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd)
   );

   smpq_cells u_cells (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_func    (in_func),
      .in_value   (req_tdata[ValueW-1:0]),
      .in_tag     (req_tdata[ReqFieldW-1:ValueW]),
      .out_status (out_status),
      .out_value  (out_value),
      .out_tag    (out_tag),
      .out_occ    (out_occ)
   );

   // Pack the response word
   assign rsp_tuser = out_status;
   assign rsp_tdata = {{(RspDataW - RspFieldW){1'b0}}, out_occ, out_tag, out_value};

endmodule

### rtl/smpq_checker.sv
// ----------------------------------------------------------------------------
// smpq_port_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smpq_port_checker
   import smpq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [1:0]          rsp_tuser,
   input logic [RspDataW-1:0] rsp_tdata
);

   logic                       req_fire;
   logic                       rsp_stall;
   logic [RspDataW+1:0]        rsp_word;
   logic                       full_rsp;
   logic                       full_ok;
   logic                       empty_rsp;
   logic                       empty_ok;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign full_rsp  = rsp_tvalid && (rsp_tuser == ST_FULL);
   assign empty_rsp = rsp_tvalid && (rsp_tuser == ST_EMPTY);

   // Full queue in the occupancy field, no entry in value and tag
   assign full_ok  = (rsp_tdata[RspFieldW-1:ValueW+TagW] == OccW'(CAPACITY)) &&
                     (rsp_tdata[ValueW+TagW-1:0] == '0);
   assign empty_ok = (rsp_tdata == '0);

   // A held result word must not change
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // One word in flight: no back-to-back acceptance
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_tready)

   // A dropped insert reports a full queue and no entry
   `ASSERT_IMPLIES(a_full_rsp, clock, reset, full_rsp, full_ok)

   // A remove on empty reports zero occupancy and no entry
   `ASSERT_IMPLIES(a_empty_rsp, clock, reset, empty_rsp, empty_ok)

endmodule

bind sorted_min_priority_queue_core smpq_port_checker u_checker (.*);
